>>> hdl/dvre_pkg.sv
// ----------------------------------------------------------------------------
// dvre_pkg
// Types and constants shared by the delta varint row id encoder modules.
// ----------------------------------------------------------------------------
package dvre_pkg;

    // Number of bytes sent for a header item
    localparam int HDR_BYTES = 8;
    localparam int HDR_CNT_W = $clog2(HDR_BYTES);

    // LEB128 byte layout
    localparam logic [7:0] VARINT_CONT = 8'h80;
    localparam logic [6:0] VARINT_DATA = 7'h7F;

    // Item kinds carried in tuser
    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_VALUE  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_VAR
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take the accepted item into the shift register
        logic emit;   // move the next byte into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;     // byte about to be emitted is the last of its item
        logic out_free; // output register can take a byte this cycle
    } t_sts;

endpackage

>>> hdl/delta_varint_row_id_encoder.sv
// ----------------------------------------------------------------------------
// delta_varint_row_id_encoder
// Encodes ascending 64-bit row ids as a delta LEB128 varint byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = mode (0 header, 1 row value); tdata[63:0] = element
//   count, tdata[127:64] = row value. A header transfer sends the count as 8
//   bytes, least significant first, and restarts the delta chain. A value
//   transfer sends one varint of 1 to 10 bytes: the value itself for the first
//   element after a header or reset, else the difference from the previous
//   value modulo 2^64.
//   Master stream: tdata = one encoded byte, tlast marks the final byte of the
//   item.
//   Timing: an item is taken while the sequencer is idle, then one byte leaves
//   per cycle while the receiver does not stall; no new item is taken while
//   the current one is still being sent. The next item is taken once the
//   last byte of the current one sits in the output register.
//   Path: the item goes into the shift register, each byte into the output register.
//   Reset: synchronous, active low; clears the output valid, the previous
//   value and sets the first-element flag.
//   Stall: while tready is low the output byte holds and the sequencer waits.
// ----------------------------------------------------------------------------
module delta_varint_row_id_encoder
    import dvre_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] element_count, [127:64] row_value
    input  logic         s_axis_tuser,  // [0] mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,  // [7:0] out_byte
    output logic         m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    dvre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    dvre_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_mode   (s_axis_tuser),
        .i_in_count  (s_axis_tdata[63:0]),
        .i_in_value  (s_axis_tdata[127:64]),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

>>> hdl/dvre_ctrl.sv
// ----------------------------------------------------------------------------
// dvre_ctrl
// Sequencer: accepts one item, then steps the datapath through its bytes.
// ----------------------------------------------------------------------------
module dvre_ctrl
    import dvre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_mode,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_mode == MODE_HEADER) ? S_HDR : S_VAR;
                end
            end
            S_HDR, S_VAR: begin
                if (i_sts.out_free && i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_HDR, S_VAR: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Load and emit are never issued together
    a_no_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.emit))
        else $error("load and emit in the same cycle");

    // Emitting the last byte returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last) |=> (r_state == S_IDLE))
        else $error("not idle after last byte");

    // A load always leaves idle
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready)
        else $error("still ready after a load");
`endif

endmodule

>>> hdl/dvre_dp.sv
// ----------------------------------------------------------------------------
// dvre_dp
// Datapath: delta subtractor, byte shift register, output register.
// ----------------------------------------------------------------------------
module dvre_dp
    import dvre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_in_mode,
    input  logic [63:0] i_in_count,
    input  logic [63:0] i_in_value,
    input  logic        i_out_ready,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last
);

    logic [63:0]          r_prev;
    logic                 r_first;
    logic [63:0]          r_shift;
    logic                 r_is_var;
    logic [HDR_CNT_W-1:0] r_hdr_cnt;
    logic                 r_ovalid;
    logic [7:0]           r_obyte;
    logic                 r_olast;

    logic [63:0] delta;
    logic        var_last;
    logic        byte_last;
    logic [7:0]  byte_next;

    // Delta against the previous value, or the value itself for the first one
    assign delta = r_first ? i_in_value : (i_in_value - r_prev);

    // Next byte and its last flag
    assign var_last  = (r_shift[63:7] == '0);
    assign byte_last = r_is_var ? var_last
                                : (r_hdr_cnt == HDR_CNT_W'(HDR_BYTES - 1));
    assign byte_next = r_is_var
        ? ({1'b0, r_shift[6:0] & VARINT_DATA} | (var_last ? 8'h00 : VARINT_CONT))
        : r_shift[7:0];

    // List state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_first <= 1'b1;
        end else if (i_cmd.load) begin
            if (i_in_mode == MODE_HEADER) begin
                r_prev  <= '0;
                r_first <= 1'b1;
            end else begin
                r_prev  <= i_in_value;
                r_first <= 1'b0;
            end
        end
    end

    // Byte shift register and header byte counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift   <= (i_in_mode == MODE_HEADER) ? i_in_count : delta;
            r_is_var  <= (i_in_mode == MODE_VALUE);
            r_hdr_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_shift   <= r_is_var ? (r_shift >> 7) : (r_shift >> 8);
            r_hdr_cnt <= r_hdr_cnt + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_obyte <= byte_next;
            r_olast <= byte_last;
        end
    end

    assign o_sts.last     = byte_last;
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_out_last     = r_olast;

`ifndef SYNTHESIS
    // A byte only goes out when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || i_out_ready))
        else $error("output register overwritten");

    // Varint bytes carry the continuation bit exactly when not last
    a_var_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_is_var) |=> (r_obyte[7] != r_olast))
        else $error("continuation bit disagrees with last flag");

    // The eighth header byte is the last one
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_is_var) |-> (byte_last == (r_hdr_cnt == HDR_CNT_W'(HDR_BYTES - 1))))
        else $error("header last flag misplaced");
`endif

endmodule

>>> tb/delta_varint_row_id_encoder_test.sv
// ----------------------------------------------------------------------------
// delta_varint_row_id_encoder_test
// Self-checking bench for the delta LEB128 row id encoder. Header and value
// items go in on the slave stream. A scoreboard keeps its own copy of the
// delta chain, predicts every encoded byte, and compares each byte and its
// tlast with the oldest prediction. Both stream sides idle at random. A long
// receiver hold-off fills the block up, and a sender pause lets it drain.
// ----------------------------------------------------------------------------
module delta_varint_row_id_encoder_test
    import dvre_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM_ITEMS = 280;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int MAX_PRINTS     = 200;

    // One encoded byte as seen on the master stream
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    // ------------------------------------------------------------------------
    // Scoreboard: delta chain predictor and queue of expected bytes
    // ------------------------------------------------------------------------
    class row_id_scoreboard;
        t_enc_byte   expected_bytes[$];
        logic [63:0] prev_row;
        bit          first_pending;
        int          errors;

        function new();
            prev_row      = '0;
            first_pending = 1'b1;
            errors        = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Append one predicted byte
        function void add_expected(t_enc_byte b);
            expected_bytes = {expected_bytes, b};
        endfunction

        // Work out the bytes caused by one accepted item
        function void note_item(logic mode, logic [63:0] count, logic [63:0] row);
            logic [63:0] rest;
            t_enc_byte   b;
            if (mode == MODE_HEADER) begin
                for (int i = 0; i < HDR_BYTES; i++) begin
                    b.data = count[8*i +: 8];
                    b.last = (i == HDR_BYTES - 1);
                    add_expected(b);
                end
                first_pending = 1'b1;
                prev_row      = '0;
            end else begin
                rest          = first_pending ? row : row - prev_row;
                first_pending = 1'b0;
                prev_row      = row;
                // 7 data bits per byte, continuation bit while more follow
                while (rest[63:7] != '0) begin
                    b.data = VARINT_CONT | {1'b0, rest[6:0]};
                    b.last = 1'b0;
                    add_expected(b);
                    rest = rest >> 7;
                end
                b.data = {1'b0, rest[6:0]};
                b.last = 1'b1;
                add_expected(b);
            end
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted output byte with the oldest prediction
        task check_byte(logic [7:0] data, logic last);
            t_enc_byte exp_b;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", data, last));
            end else begin
                exp_b = expected_bytes.pop_front();
                if (data !== exp_b.data)
                    report($sformatf("tdata %02h, expected %02h", data, exp_b.data));
                if (last !== exp_b.last)
                    report($sformatf("tlast %0b, expected %0b", last, exp_b.last));
            end
        endtask

        task check_drained();
            if (expected_bytes.size() != 0)
                report($sformatf("%0d bytes never arrived", expected_bytes.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;   // [63:0] element_count, [127:64] row_value
    logic         s_axis_tuser  = 1'b0; // [0] mode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;         // [7:0] out_byte
    logic         m_axis_tlast;

    row_id_scoreboard sb;
    int  cycles    = 0;
    int  tx_quiet  = 0;
    int  sent      = 0;
    bit  hold_req  = 1'b0;
    logic rx_hold  = 1'b0;

    delta_varint_row_id_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Idle cycles before a transfer; now and then a quiet stretch with none
    function automatic int pick_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random value of a random bit width, small widths favoured
    function automatic logic [63:0] rand_delta();
        int w;
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 14);
        if (w >= 64)
            return rand64();
        return rand64() & ((64'd1 << w) - 64'd1);
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic mode, input logic [63:0] count,
                             input logic [63:0] row);
        int gap;
        gap = pick_wait(tx_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, count};
        s_axis_tuser  <= mode;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_item(mode, count, row);
        sent++;
    endtask

    task automatic send_header(input logic [63:0] count);
        send_item(MODE_HEADER, count, rand64());
    endtask

    task automatic send_row(input logic [63:0] row);
        send_item(MODE_VALUE, rand64(), row);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off when asked
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = pick_wait(quiet);
            if (stall > 0 || rx_hold)
                m_axis_tready <= 1'b0;
            repeat (stall) @(posedge i_clk);
            while (rx_hold) @(posedge i_clk);
            m_axis_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!m_axis_tvalid);
            sb.check_byte(m_axis_tdata, m_axis_tlast);
        end
    end

    // Long receiver hold-off, counted here
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Cycle limit
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("delta_varint_row_id_encoder_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [63:0] row;
        int          n;
        int          kind;
        bit          paused;

        sb     = new();
        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: value before any header is taken as a first element
        send_row(64'd5);
        send_row(64'd300);                    // two-byte delta
        send_row(64'd300);                    // repeated value, single zero byte
        send_row(64'd299);                    // descending, wraps to ten bytes
        send_header(64'd0);
        send_row(64'd0);                      // zero first element
        send_row(64'hFFFF_FFFF_FFFF_FFFF);    // largest delta
        send_header(64'hFFFF_FFFF_FFFF_FFFF);
        send_row(64'd127);                    // largest single byte
        send_row(64'd255);                    // delta 128, first two-byte case
        send_row(64'd16638);                  // delta 16383
        send_row(64'd16639);                  // delta 1
        send_header(64'h0123_4567_89AB_CDEF);
        send_row(64'h8000_0000_0000_0000);    // top bit set, ten bytes
        send_row(64'h8100_0000_0000_0000);
        send_header(64'd3);                   // header mid list restarts chain
        send_row(64'd1000);
        send_row(64'd1001);                   // count mismatch: more than 3
        send_row(64'd1002);
        send_row(64'd1003);
        send_row(64'd1003);
        send_header(64'hFEDC_BA98_7654_3210);
        send_row(64'h0000_0000_FFFF_FFFF);

        // Sender pause until everything has drained, then the hold-off
        s_axis_tvalid <= 1'b0;
        wait_drained();
        hold_req = 1'b1;

        // Random: mostly well-formed lists, some noise and broken lists
        sent = 0;
        while (sent < N_RANDOM_ITEMS) begin
            if (!paused && sent >= N_RANDOM_ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                n = $urandom_range(0, 6);
                send_header((kind == 0) ? rand64() : 64'(n));
                row = ($urandom_range(0, 1) == 0) ? rand_delta() : rand64();
                // occasionally one value fewer or more than announced
                if ($urandom_range(0, 4) == 0)
                    n = n + $urandom_range(0, 2) - 1;
                for (int i = 0; i < n; i++) begin
                    if (i > 0)
                        row = row + rand_delta();
                    send_row(row);
                end
            end else if (kind == 7) begin
                send_row(rand64());
            end else if (kind == 8) begin
                send_header(rand64());
            end else begin
                // descending or repeated values
                row = rand64();
                send_row(row);
                send_row(row - rand_delta());
                send_row(row);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain and finish
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("delta_varint_row_id_encoder_test: PASS");
        end else begin
            $display("delta_varint_row_id_encoder_test: FAIL");
        end
        $finish;
    end

endmodule
